@@ design/cpr_pkg.sv @@
// shared types, codes and defaults for the contact rattler pruning block
package cpr_pkg;

   // default sizing
   localparam int MAX_PARTICLES_DEF = 64;
   localparam int PASS_LIMIT_DEF    = 100;

   // command codes
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_PRUNE = 2'd2;

   // register indexes
   localparam logic REG_PARTICLE_COUNT    = 1'b0;
   localparam logic REG_MAX_FREE_CONTACTS = 1'b1;

   // register reset values
   localparam logic [6:0] PARTICLE_COUNT_RST    = 7'd64;
   localparam logic [5:0] MAX_FREE_CONTACTS_RST = 6'd3;

   // saturation limit of the reported rattler count
   localparam logic [6:0] RATTLER_SAT = 7'd127;

   // input item
   typedef struct packed {
      logic [1:0] command;
      logic [5:0] first_particle;
      logic [5:0] second_particle;
   } req_type;

   // result item
   typedef struct packed {
      logic [6:0] rattler_count;
      logic       depth_exceeded;
      logic       contact_added;
   } rsp_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_ADD_A,
      ST_ADD_B,
      ST_ADD_W,
      ST_P_START,
      ST_P_RD,
      ST_P_CHK,
      ST_SCAN,
      ST_DRAIN,
      ST_P_END,
      ST_FINISH
   } state_type;

endpackage

@@ design/cpr_ram.sv @@
// generic simple dual port ram with registered read
module cpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/contact_rattler_pruning.sv @@
// contact network store with iterative rattler pruning
// prune: each pass checks every particle in use, and each rattler with contacts then
//    walks its row of the contact ram; the result is formed after the last pass
// one item at a time; the next item is taken once the result is in the output register
// reset: synchronous; a clearing pass sweeps both rams, one row a cycle, and no item
//    is accepted until it ends
module contact_rattler_pruning #(
   parameter int MAX_PARTICLES = cpr_pkg::MAX_PARTICLES_DEF,
   parameter int PASS_LIMIT    = cpr_pkg::PASS_LIMIT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cpr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cpr_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [6:0]       csr_wdata
);

   localparam int IW  = $clog2(MAX_PARTICLES);
   localparam int CW  = $clog2(MAX_PARTICLES);
   localparam int NW  = $clog2(MAX_PARTICLES + 1);
   localparam int PW  = $clog2(PASS_LIMIT + 2);
   localparam int TW  = ((CW > 6) ? CW : 6) + 1;
   localparam int NCW = (NW > 7) ? NW : 7;
   localparam int SW  = (NW > 7) ? NW : 7;
   localparam int MW  = MAX_PARTICLES;

   // configuration registers
   logic [6:0] part_cnt_ff, part_cnt_in;
   logic [5:0] max_free_ff, max_free_in;

   // control state
   cpr_pkg::state_type state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [NW-1:0] i_ff, i_in;
   logic [NW-1:0] jc_ff, jc_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic          removed_ff, removed_in;
   logic          pend_v_ff, pend_v_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [IW-1:0]    a_ff, a_in;
   logic [IW-1:0]    b_ff, b_in;
   logic [MW-1:0]    snap_ff, snap_in;
   logic [IW-1:0]    pend_j_ff, pend_j_in;
   logic [NW-1:0]    rat_ff, rat_in;
   logic             depth_ff, depth_in;
   logic             added_ff, added_in;
   cpr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ram ports
   logic          row_we, cnt_we;
   logic [IW-1:0] row_waddr, cnt_waddr, rd_addr;
   logic [MW-1:0] row_wdata, row_rdata;
   logic [CW-1:0] cnt_wdata, cnt_rdata;

   // derived values
   logic [NW-1:0] n_used;
   logic [MW-1:0] low_mask;
   logic [IW-1:0] i_idx, jc_idx, req_a, req_b;
   logic [NW-1:0] i_next, jc_next;
   logic          pair_ok, slot_free;
   logic [CW-1:0] cnt_dec;

   // contact rows: row k holds one bit for each partner of particle k
   cpr_ram #(.WIDTH(MW), .DEPTH(MAX_PARTICLES)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_waddr),
      .wr_data (row_wdata),
      .rd_addr (rd_addr),
      .rd_data (row_rdata)
   );

   // contact count of each particle
   cpr_ram #(.WIDTH(CW), .DEPTH(MAX_PARTICLES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (rd_addr),
      .rd_data (cnt_rdata)
   );

   // particles in use, limited to the store size
   assign n_used = (NCW'(part_cnt_ff) >= NCW'(MAX_PARTICLES)) ? NW'(MAX_PARTICLES)
                                                             : NW'(part_cnt_ff);

   // mask of partners below the particle count
   for (genvar k = 0; k < MW; k++) begin : g_low
      assign low_mask[k] = (NCW'(k) < NCW'(n_used));
   end

   assign i_idx   = i_ff[IW-1:0];
   assign jc_idx  = jc_ff[IW-1:0];
   assign i_next  = i_ff + NW'(1);
   assign jc_next = jc_ff + NW'(1);
   assign req_a   = IW'(req_data.first_particle);
   assign req_b   = IW'(req_data.second_particle);
   assign cnt_dec = (cnt_rdata != '0) ? (cnt_rdata - CW'(1)) : '0;

   // pair check on the incoming item
   assign pair_ok = (req_data.first_particle != req_data.second_particle)
                 && (NCW'(req_data.first_particle) < NCW'(n_used))
                 && (NCW'(req_data.second_particle) < NCW'(n_used));

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == cpr_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration writes
   always_comb begin
      part_cnt_in = part_cnt_ff;
      max_free_in = max_free_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            cpr_pkg::REG_PARTICLE_COUNT:    part_cnt_in = csr_wdata;
            cpr_pkg::REG_MAX_FREE_CONTACTS: max_free_in = csr_wdata[5:0];
         endcase
      end
   end

   // sequencer: next state, ram accesses and result
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_rsp_in   = clr_rsp_ff;
      i_in         = i_ff;
      jc_in        = jc_ff;
      pass_in      = pass_ff;
      removed_in   = removed_ff;
      pend_v_in    = pend_v_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      snap_in      = snap_ff;
      pend_j_in    = pend_j_ff;
      rat_in       = rat_ff;
      depth_in     = depth_ff;
      added_in     = added_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      row_we       = 1'b0;
      cnt_we       = 1'b0;
      row_waddr    = i_idx;
      cnt_waddr    = i_idx;
      row_wdata    = '0;
      cnt_wdata    = '0;
      rd_addr      = i_idx;

      unique case (state_ff)
         cpr_pkg::ST_IDLE: begin
            if (req_valid) begin
               rat_in   = '0;
               depth_in = 1'b0;
               added_in = 1'b0;
               a_in     = req_a;
               b_in     = req_b;
               unique case (req_data.command)
                  cpr_pkg::CMD_CLEAR: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = cpr_pkg::ST_CLEAR;
                  end
                  cpr_pkg::CMD_ADD: begin
                     state_in = pair_ok ? cpr_pkg::ST_ADD_A : cpr_pkg::ST_FINISH;
                  end
                  cpr_pkg::CMD_PRUNE: begin
                     pass_in  = '0;
                     state_in = cpr_pkg::ST_P_START;
                  end
                  default: begin
                     state_in = cpr_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         // sweep both rams to zero, one row a cycle
         cpr_pkg::ST_CLEAR: begin
            row_we    = 1'b1;
            cnt_we    = 1'b1;
            row_waddr = clr_ff;
            cnt_waddr = clr_ff;
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == IW'(MAX_PARTICLES - 1)) begin
               state_in = clr_rsp_ff ? cpr_pkg::ST_FINISH : cpr_pkg::ST_IDLE;
            end
         end

         // read row and count of the first particle
         cpr_pkg::ST_ADD_A: begin
            rd_addr  = a_ff;
            state_in = cpr_pkg::ST_ADD_B;
         end

         // pair already present: nothing to do, else set it in the first row
         cpr_pkg::ST_ADD_B: begin
            rd_addr = b_ff;
            if (row_rdata[b_ff]) begin
               state_in = cpr_pkg::ST_FINISH;
            end else begin
               row_we    = 1'b1;
               cnt_we    = 1'b1;
               row_waddr = a_ff;
               cnt_waddr = a_ff;
               row_wdata = row_rdata | (MW'(1) << b_ff);
               cnt_wdata = cnt_rdata + CW'(1);
               state_in  = cpr_pkg::ST_ADD_W;
            end
         end

         // mirror the pair into the second row
         cpr_pkg::ST_ADD_W: begin
            row_we    = 1'b1;
            cnt_we    = 1'b1;
            row_waddr = b_ff;
            cnt_waddr = b_ff;
            row_wdata = row_rdata | (MW'(1) << a_ff);
            cnt_wdata = cnt_rdata + CW'(1);
            added_in  = 1'b1;
            state_in  = cpr_pkg::ST_FINISH;
         end

         // open a pass
         cpr_pkg::ST_P_START: begin
            pass_in    = pass_ff + PW'(1);
            i_in       = '0;
            rat_in     = '0;
            removed_in = 1'b0;
            state_in   = (n_used == '0) ? cpr_pkg::ST_P_END : cpr_pkg::ST_P_RD;
         end

         cpr_pkg::ST_P_RD: begin
            rd_addr  = i_idx;
            state_in = cpr_pkg::ST_P_CHK;
         end

         // rattler test on particle i
         cpr_pkg::ST_P_CHK: begin
            if ((TW'(cnt_rdata) > TW'(max_free_ff)) || (cnt_rdata == '0)) begin
               if (!(TW'(cnt_rdata) > TW'(max_free_ff))) begin
                  rat_in = rat_ff + NW'(1);
                  cnt_we = 1'b1;
               end
               if (i_next == n_used) begin
                  state_in = cpr_pkg::ST_P_END;
               end else begin
                  i_in     = i_next;
                  state_in = cpr_pkg::ST_P_RD;
               end
            end else begin
               rat_in     = rat_ff + NW'(1);
               removed_in = 1'b1;
               cnt_we     = 1'b1;
               row_we     = 1'b1;
               row_wdata  = row_rdata & ~low_mask;
               snap_in    = row_rdata & low_mask;
               jc_in      = '0;
               pend_v_in  = 1'b0;
               state_in   = cpr_pkg::ST_SCAN;
            end
         end

         // walk the partners: read one, write back the one before
         cpr_pkg::ST_SCAN: begin
            rd_addr   = jc_idx;
            row_we    = pend_v_ff;
            cnt_we    = pend_v_ff;
            row_waddr = pend_j_ff;
            cnt_waddr = pend_j_ff;
            row_wdata = row_rdata & ~(MW'(1) << i_idx);
            cnt_wdata = cnt_dec;
            pend_v_in = snap_ff[0];
            pend_j_in = jc_idx;
            snap_in   = snap_ff >> 1;
            jc_in     = jc_next;
            if (jc_next == n_used) begin
               state_in = cpr_pkg::ST_DRAIN;
            end
         end

         // last partner write, then the next particle or the end of the pass
         cpr_pkg::ST_DRAIN: begin
            row_we    = pend_v_ff;
            cnt_we    = pend_v_ff;
            row_waddr = pend_j_ff;
            cnt_waddr = pend_j_ff;
            row_wdata = row_rdata & ~(MW'(1) << i_idx);
            cnt_wdata = cnt_dec;
            pend_v_in = 1'b0;
            if (i_next == n_used) begin
               state_in = cpr_pkg::ST_P_END;
            end else begin
               i_in     = i_next;
               state_in = cpr_pkg::ST_P_RD;
            end
         end

         // pass limit, settled network or another pass
         cpr_pkg::ST_P_END: begin
            if (pass_ff > PW'(PASS_LIMIT)) begin
               depth_in = 1'b1;
               rat_in   = '0;
               state_in = cpr_pkg::ST_FINISH;
            end else if (!removed_ff) begin
               state_in = cpr_pkg::ST_FINISH;
            end else begin
               state_in = cpr_pkg::ST_P_START;
            end
         end

         // hand the result item to the output register
         cpr_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.rattler_count   = (SW'(rat_ff) > SW'(cpr_pkg::RATTLER_SAT))
                                             ? cpr_pkg::RATTLER_SAT : 7'(rat_ff);
               rsp_data_in.depth_exceeded  = depth_ff;
               rsp_data_in.contact_added   = added_ff;
               clr_rsp_in                  = 1'b0;
               state_in                    = cpr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cpr_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cpr_pkg::ST_CLEAR;
         clr_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         i_ff         <= '0;
         jc_ff        <= '0;
         pass_ff      <= '0;
         removed_ff   <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         part_cnt_ff  <= cpr_pkg::PARTICLE_COUNT_RST;
         max_free_ff  <= cpr_pkg::MAX_FREE_CONTACTS_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_rsp_ff   <= clr_rsp_in;
         i_ff         <= i_in;
         jc_ff        <= jc_in;
         pass_ff      <= pass_in;
         removed_ff   <= removed_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
         part_cnt_ff  <= part_cnt_in;
         max_free_ff  <= max_free_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      snap_ff     <= snap_in;
      pend_j_ff   <= pend_j_in;
      rat_ff      <= rat_in;
      depth_ff    <= depth_in;
      added_ff    <= added_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a result item only appears out of the finishing state
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == cpr_pkg::ST_FINISH))
      else $error("result item without finishing state");

   // the partner walk never writes the row it is reading
   a_scan_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cpr_pkg::ST_SCAN && pend_v_ff) |-> (pend_j_ff != jc_idx))
      else $error("partner walk read and write collide");

   // pass counter stops one past the limit
   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cpr_pkg::ST_IDLE) |-> (pass_ff <= PW'(PASS_LIMIT + 1)))
      else $error("pass counter beyond limit");

   // only one kind of result flag per item
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.depth_exceeded
                         && (rsp_data_ff.contact_added || rsp_data_ff.rattler_count != '0)))
      else $error("conflicting result flags");

endmodule
